// ----- design/urbe_pkg.sv -----
// urbe_pkg: shared types and constants for the UART ring buffer engine.
// No dependencies; imported by the top level, urbe_ctrl and urbe_dp.
package urbe_pkg;

  localparam int TX_DEPTH_DEF = 256;
  localparam int RX_DEPTH_DEF = 256;
  localparam int BYTE_W       = 8;
  localparam int ERR_CNT_W    = 32;
  localparam int LEVEL_MAX    = 255;   // tx_free / rx_count saturate here

  // item kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_PURGE = 2'd3
  } kind_t;

  // controller -> datapath commands
  typedef struct packed {
    logic exec;     // execute the item on the input ports this cycle
    logic cfg_wr;   // write the echo_enable register
  } cmd_t;

endpackage

// ----- design/uart_ring_buffer_engine_core.sv -----
// uart_ring_buffer_engine_core: top level of the UART ring buffer engine.
// Depends on urbe_pkg, urbe_ctrl, urbe_dp (which uses urbe_ram).
//
// Sits between a host and one UART. Each input transfer carries one item
// (host write, host read, line event or receive purge) and produces exactly
// one result transfer. Transmit and receive rings hold up to depth-1 bytes
// each; a refused host write also refuses the rest of its burst, up to and
// including the byte marked burst_end. Line events bump four wrapping 32-bit
// error counters, store the received byte when there is room, echo it when
// echo_enable is set (even if dropped), and hand the oldest queued byte to
// the transmitter when tx_ready is set. Timing: an item is taken in the
// cycle in_valid is seen with in_stall low, all pointer and ring updates
// happen at that edge, and the result is on out_* the next cycle; in_stall
// stays high until the result transfer, so no new item is taken while a
// result is outstanding; read bytes come from the registered RAM read port.
// The ring RAMs have no reset; no clearing pass is needed. echo_enable is
// written through cfg_valid/cfg_ready, and cfg_ready is high only while no
// item is outstanding and in_valid is low.
module uart_ring_buffer_engine_core
  import urbe_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [BYTE_W-1:0]    in_byte_value,
  input  logic                 in_burst_end,
  input  logic                 in_rx_valid,
  input  logic                 in_framing_error,
  input  logic                 in_parity_error,
  input  logic                 in_noise_error,
  input  logic                 in_overrun_error,
  input  logic                 in_tx_ready,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_echo_valid,
  output logic [BYTE_W-1:0]    out_echo_byte,
  output logic                 out_send_valid,
  output logic [BYTE_W-1:0]    out_send_byte,
  output logic [BYTE_W-1:0]    out_tx_free,
  output logic [BYTE_W-1:0]    out_rx_count,
  output logic [ERR_CNT_W-1:0] out_framing_count,
  output logic [ERR_CNT_W-1:0] out_parity_count,
  output logic [ERR_CNT_W-1:0] out_noise_count,
  output logic [ERR_CNT_W-1:0] out_overrun_count,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_echo_enable
);

  cmd_t cmd;

  // handshake sequencing
  urbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // rings, pointers, counters and result registers
  urbe_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_echo_enable   (cfg_echo_enable),
    .in_kind           (in_kind),
    .in_byte_value     (in_byte_value),
    .in_burst_end      (in_burst_end),
    .in_rx_valid       (in_rx_valid),
    .in_framing_error  (in_framing_error),
    .in_parity_error   (in_parity_error),
    .in_noise_error    (in_noise_error),
    .in_overrun_error  (in_overrun_error),
    .in_tx_ready       (in_tx_ready),
    .out_status        (out_status),
    .out_read_byte     (out_read_byte),
    .out_echo_valid    (out_echo_valid),
    .out_echo_byte     (out_echo_byte),
    .out_send_valid    (out_send_valid),
    .out_send_byte     (out_send_byte),
    .out_tx_free       (out_tx_free),
    .out_rx_count      (out_rx_count),
    .out_framing_count (out_framing_count),
    .out_parity_count  (out_parity_count),
    .out_noise_count   (out_noise_count),
    .out_overrun_count (out_overrun_count)
  );

endmodule

// ----- design/urbe_ram.sv -----
// urbe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module urbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/urbe_ctrl.sv -----
// urbe_ctrl: handshake controller; accepts one item, then holds the result
// until the output transfer. Depends on urbe_pkg.
module urbe_ctrl
  import urbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic cfg_valid,
  output logic cfg_ready,
  output cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt     = ST_RESP;
          in_stall_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_stall) begin
          state_nxt     = ST_IDLE;
          in_stall_nxt  = 1'b0;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        in_stall_nxt  = 1'b0;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall   = in_stall_r;
  assign out_valid  = out_valid_r;
  // no register write while an item is held or being offered
  assign cfg_ready  = (state_r == ST_IDLE) && !in_valid;
  assign cmd.exec   = in_valid && !in_stall_r;
  assign cmd.cfg_wr = cfg_valid && cfg_ready;

  // a result on display always blocks new input
  a_resp_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall_r) else $error("result shown while input open");

  // an executed item always produces a result next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (out_valid_r && state_r == ST_RESP))
    else $error("executed item without result");

endmodule

// ----- design/urbe_dp.sv -----
// urbe_dp: ring pointers, rings, error counters, echo register and result
// registers. Depends on urbe_pkg and urbe_ram.
module urbe_dp
  import urbe_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic                 cfg_echo_enable,
  input  logic [1:0]           in_kind,
  input  logic [BYTE_W-1:0]    in_byte_value,
  input  logic                 in_burst_end,
  input  logic                 in_rx_valid,
  input  logic                 in_framing_error,
  input  logic                 in_parity_error,
  input  logic                 in_noise_error,
  input  logic                 in_overrun_error,
  input  logic                 in_tx_ready,
  output logic                 out_status,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_echo_valid,
  output logic [BYTE_W-1:0]    out_echo_byte,
  output logic                 out_send_valid,
  output logic [BYTE_W-1:0]    out_send_byte,
  output logic [BYTE_W-1:0]    out_tx_free,
  output logic [BYTE_W-1:0]    out_rx_count,
  output logic [ERR_CNT_W-1:0] out_framing_count,
  output logic [ERR_CNT_W-1:0] out_parity_count,
  output logic [ERR_CNT_W-1:0] out_noise_count,
  output logic [ERR_CNT_W-1:0] out_overrun_count
);

  localparam int TPW = $clog2(TX_DEPTH);
  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TCW = (TPW + 1 > 9) ? TPW + 1 : 9;
  localparam int RCW = (RPW + 1 > 9) ? RPW + 1 : 9;

  function automatic logic [TPW-1:0] tx_adv(input logic [TPW-1:0] p);
    return (p == TPW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RPW-1:0] rx_adv(input logic [RPW-1:0] p);
    return (p == RPW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  kind_t kind;
  assign kind = kind_t'(in_kind);

  logic [TPW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [RPW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic           burst_r, burst_nxt;
  logic           echo_en_r;
  logic [ERR_CNT_W-1:0] frame_r, parity_r, noise_r, overrun_r;

  // result registers
  logic              status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              evalid_r, evalid_nxt;
  logic [BYTE_W-1:0] ebyte_r, ebyte_nxt;
  logic              svalid_r, svalid_nxt;

  // ring ports
  logic              tx_we, tx_re, rx_we, rx_re;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;

  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    burst_nxt   = burst_r;
    status_nxt  = 1'b0;
    rd_ok_nxt   = 1'b0;
    evalid_nxt  = 1'b0;
    ebyte_nxt   = '0;
    svalid_nxt  = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    if (cmd.exec) begin
      unique case (kind)
        KIND_WRITE: begin
          if (burst_r || tx_adv(tx_head_r) == tx_tail_r) begin
            status_nxt = 1'b1;
            burst_nxt  = 1'b1;
          end else begin
            tx_we       = 1'b1;
            tx_head_nxt = tx_adv(tx_head_r);
          end
          if (in_burst_end) begin
            burst_nxt = 1'b0;
          end
        end
        KIND_READ: begin
          if (rx_head_r == rx_tail_r) begin
            status_nxt = 1'b1;
          end else begin
            rd_ok_nxt   = 1'b1;
            rx_re       = 1'b1;
            rx_tail_nxt = rx_adv(rx_tail_r);
          end
        end
        KIND_LINE: begin
          if (in_rx_valid) begin
            if (echo_en_r) begin
              evalid_nxt = 1'b1;
              ebyte_nxt  = in_byte_value;
            end
            if (rx_adv(rx_head_r) != rx_tail_r) begin
              rx_we       = 1'b1;
              rx_head_nxt = rx_adv(rx_head_r);
            end
          end
          if (in_tx_ready && tx_tail_r != tx_head_r) begin
            svalid_nxt  = 1'b1;
            tx_re       = 1'b1;
            tx_tail_nxt = tx_adv(tx_tail_r);
          end
        end
        KIND_PURGE: begin
          rx_head_nxt = '0;
          rx_tail_nxt = '0;
        end
        default: begin
          status_nxt = 1'b0;
        end
      endcase
    end
  end

  logic line_ev;
  assign line_ev = cmd.exec && (kind == KIND_LINE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= '0;
      tx_tail_r <= '0;
      rx_head_r <= '0;
      rx_tail_r <= '0;
      burst_r   <= 1'b0;
      echo_en_r <= 1'b0;
      frame_r   <= '0;
      parity_r  <= '0;
      noise_r   <= '0;
      overrun_r <= '0;
    end else begin
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      burst_r   <= burst_nxt;
      if (cmd.cfg_wr) begin
        echo_en_r <= cfg_echo_enable;
      end
      if (line_ev && in_framing_error) frame_r   <= frame_r + 1'b1;
      if (line_ev && in_parity_error)  parity_r  <= parity_r + 1'b1;
      if (line_ev && in_noise_error)   noise_r   <= noise_r + 1'b1;
      if (line_ev && in_overrun_error) overrun_r <= overrun_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
      evalid_r <= evalid_nxt;
      ebyte_r  <= ebyte_nxt;
      svalid_r <= svalid_nxt;
    end
  end

  urbe_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_r),
    .wdata (in_byte_value),
    .re    (tx_re),
    .raddr (tx_tail_r),
    .rdata (tx_rdata)
  );

  urbe_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_r),
    .wdata (in_byte_value),
    .re    (rx_re),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  // fill levels, saturated to one byte
  logic [TCW-1:0] tx_used, tx_free_w;
  logic [RCW-1:0] rx_used;

  always_comb begin
    if (tx_head_r >= tx_tail_r) begin
      tx_used = TCW'(tx_head_r) - TCW'(tx_tail_r);
    end else begin
      tx_used = TCW'(tx_head_r) + TCW'(TX_DEPTH) - TCW'(tx_tail_r);
    end
    if (rx_head_r >= rx_tail_r) begin
      rx_used = RCW'(rx_head_r) - RCW'(rx_tail_r);
    end else begin
      rx_used = RCW'(rx_head_r) + RCW'(RX_DEPTH) - RCW'(rx_tail_r);
    end
    tx_free_w = TCW'(TX_DEPTH - 1) - tx_used;
  end

  assign out_tx_free  = (tx_free_w > TCW'(LEVEL_MAX)) ? BYTE_W'(LEVEL_MAX)
                                                      : tx_free_w[BYTE_W-1:0];
  assign out_rx_count = (rx_used > RCW'(LEVEL_MAX)) ? BYTE_W'(LEVEL_MAX)
                                                    : rx_used[BYTE_W-1:0];

  assign out_status        = status_r;
  assign out_read_byte     = rd_ok_r ? rx_rdata : '0;
  assign out_echo_valid    = evalid_r;
  assign out_echo_byte     = ebyte_r;
  assign out_send_valid    = svalid_r;
  assign out_send_byte     = svalid_r ? tx_rdata : '0;
  assign out_framing_count = frame_r;
  assign out_parity_count  = parity_r;
  assign out_noise_count   = noise_r;
  assign out_overrun_count = overrun_r;

  a_purge_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && kind == KIND_PURGE) |=> (rx_head_r == '0 && rx_tail_r == '0))
    else $error("purge left receive pointers set");

  a_purge_keeps_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && kind == KIND_PURGE) |=> ($stable(tx_head_r) && $stable(tx_tail_r)))
    else $error("purge touched transmit ring");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (TPW'(tx_head_r) <= TPW'(TX_DEPTH - 1)) && (RPW'(rx_head_r) <= RPW'(RX_DEPTH - 1)))
    else $error("ring pointer out of range");

  a_send_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && svalid_nxt) |-> (tx_used != '0))
    else $error("send from empty transmit ring");

endmodule

// ----- tb/uart_ring_buffer_engine_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for uart_ring_buffer_engine_core: ring-level predictor,
// scoreboard class and random valid/stall traffic on both channels.
// Depends on urbe_pkg and the block's RTL only.
module uart_ring_buffer_engine_core_tb;
  import urbe_pkg::*;

  // one item as carried by the input channel
  typedef struct {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic        burst_end;
    logic        rx_valid;
    logic        framing_error;
    logic        parity_error;
    logic        noise_error;
    logic        overrun_error;
    logic        tx_ready;
  } item_t;

  // one result as carried by the output channel
  typedef struct {
    logic        status;
    logic [7:0]  read_byte;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic [7:0]  tx_free;
    logic [7:0]  rx_count;
    logic [31:0] framing_count;
    logic [31:0] parity_count;
    logic [31:0] noise_count;
    logic [31:0] overrun_count;
  } result_t;

  // traffic shapes for the random part
  typedef enum int {SEG_MIX, SEG_FILL_TX, SEG_FILL_RX, SEG_DRAIN} seg_mode_t;

  // Scoreboard: mirrors both rings, burst refusal and error counters, and
  // queues the result each accepted item should produce.
  class uart_ring_scoreboard;
    logic [7:0]  tx_ring [TX_DEPTH_DEF];
    logic [7:0]  rx_ring [RX_DEPTH_DEF];
    int unsigned tx_wr, tx_rd, rx_wr, rx_rd;
    bit          refusing;
    logic [31:0] n_framing, n_parity, n_noise, n_overrun;
    bit          echo_on;
    result_t     due_results[$];
    int          errors, items, n_refused, n_dropped, n_echoed, n_sent, n_read;

    function int pending();
      return due_results.size();
    endfunction

    function logic [7:0] level8(int unsigned v);
      return (v > LEVEL_MAX) ? 8'(LEVEL_MAX) : 8'(v);
    endfunction

    function void apply_item(item_t it);
      result_t     r;
      int unsigned nxt;
      r = '{default: '0};
      items++;
      case (it.kind)
        KIND_WRITE: begin
          nxt = (tx_wr + 1) % TX_DEPTH_DEF;
          if (refusing || nxt == tx_rd) begin
            r.status = 1'b1;
            refusing = 1'b1;
            n_refused++;
          end else begin
            tx_ring[tx_wr] = it.byte_value;
            tx_wr = nxt;
          end
          if (it.burst_end) refusing = 1'b0;
        end
        KIND_READ: begin
          if (rx_wr == rx_rd) begin
            r.status = 1'b1;
          end else begin
            r.read_byte = rx_ring[rx_rd];
            rx_rd = (rx_rd + 1) % RX_DEPTH_DEF;
            n_read++;
          end
        end
        KIND_LINE: begin
          if (it.framing_error) n_framing++;
          if (it.parity_error)  n_parity++;
          if (it.noise_error)   n_noise++;
          if (it.overrun_error) n_overrun++;
          if (it.rx_valid) begin
            nxt = (rx_wr + 1) % RX_DEPTH_DEF;
            if (echo_on) begin
              r.echo_valid = 1'b1;
              r.echo_byte  = it.byte_value;
              n_echoed++;
            end
            // a full ring drops the byte but the echo still goes out
            if (nxt != rx_rd) begin
              rx_ring[rx_wr] = it.byte_value;
              rx_wr = nxt;
            end else begin
              n_dropped++;
            end
          end
          if (it.tx_ready && tx_rd != tx_wr) begin
            r.send_valid = 1'b1;
            r.send_byte  = tx_ring[tx_rd];
            tx_rd = (tx_rd + 1) % TX_DEPTH_DEF;
            n_sent++;
          end
        end
        KIND_PURGE: begin
          rx_wr = 0;
          rx_rd = 0;
        end
      endcase
      r.tx_free = level8(TX_DEPTH_DEF - 1 - (tx_wr + TX_DEPTH_DEF - tx_rd) % TX_DEPTH_DEF);
      r.rx_count = level8((rx_wr + RX_DEPTH_DEF - rx_rd) % RX_DEPTH_DEF);
      r.framing_count = n_framing;
      r.parity_count  = n_parity;
      r.noise_count   = n_noise;
      r.overrun_count = n_overrun;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status",        want.status,        got.status);
      compare_field("read_byte",     want.read_byte,     got.read_byte);
      compare_field("echo_valid",    want.echo_valid,    got.echo_valid);
      compare_field("echo_byte",     want.echo_byte,     got.echo_byte);
      compare_field("send_valid",    want.send_valid,    got.send_valid);
      compare_field("send_byte",     want.send_byte,     got.send_byte);
      compare_field("tx_free",       want.tx_free,       got.tx_free);
      compare_field("rx_count",      want.rx_count,      got.rx_count);
      compare_field("framing_count", want.framing_count, got.framing_count);
      compare_field("parity_count",  want.parity_count,  got.parity_count);
      compare_field("noise_count",   want.noise_count,   got.noise_count);
      compare_field("overrun_count", want.overrun_count, got.overrun_count);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_WRITE;
  logic [7:0]  in_byte_value = '0;
  logic        in_burst_end = 1'b0;
  logic        in_rx_valid = 1'b0;
  logic        in_framing_error = 1'b0;
  logic        in_parity_error = 1'b0;
  logic        in_noise_error = 1'b0;
  logic        in_overrun_error = 1'b0;
  logic        in_tx_ready = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic [7:0]  out_read_byte, out_echo_byte, out_send_byte, out_tx_free, out_rx_count;
  logic        out_echo_valid, out_send_valid;
  logic [31:0] out_framing_count, out_parity_count, out_noise_count, out_overrun_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_echo_enable = 1'b0;

  uart_ring_scoreboard sb = new();

  // idle_pct: chance (percent) of an idle burst before each transfer on
  // either side; zero gives stretches of back-to-back traffic
  int unsigned idle_pct = 25;
  int          stall_left = 0;
  int          burst_left = 0;

  uart_ring_buffer_engine_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_byte_value     (in_byte_value),
    .in_burst_end      (in_burst_end),
    .in_rx_valid       (in_rx_valid),
    .in_framing_error  (in_framing_error),
    .in_parity_error   (in_parity_error),
    .in_noise_error    (in_noise_error),
    .in_overrun_error  (in_overrun_error),
    .in_tx_ready       (in_tx_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_read_byte     (out_read_byte),
    .out_echo_valid    (out_echo_valid),
    .out_echo_byte     (out_echo_byte),
    .out_send_valid    (out_send_valid),
    .out_send_byte     (out_send_byte),
    .out_tx_free       (out_tx_free),
    .out_rx_count      (out_rx_count),
    .out_framing_count (out_framing_count),
    .out_parity_count  (out_parity_count),
    .out_noise_count   (out_noise_count),
    .out_overrun_count (out_overrun_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_echo_enable   (cfg_echo_enable)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run (~2k items).
  initial begin
    #20_000_000;
    $display("[uart_ring_buffer_engine_core] ERROR");
    $finish;
  end

  // Receiver: random stall bursts on out_stall.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitors: everything is sampled at the edge where the transfer happens.
  // Results are checked before the new item is predicted; a result always
  // belongs to an item taken at an earlier edge.
  always @(posedge clk) begin
    result_t got;
    item_t   took;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status        = out_status;
        got.read_byte     = out_read_byte;
        got.echo_valid    = out_echo_valid;
        got.echo_byte     = out_echo_byte;
        got.send_valid    = out_send_valid;
        got.send_byte     = out_send_byte;
        got.tx_free       = out_tx_free;
        got.rx_count      = out_rx_count;
        got.framing_count = out_framing_count;
        got.parity_count  = out_parity_count;
        got.noise_count   = out_noise_count;
        got.overrun_count = out_overrun_count;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) begin
        took.kind          = kind_t'(in_kind);
        took.byte_value    = in_byte_value;
        took.burst_end     = in_burst_end;
        took.rx_valid      = in_rx_valid;
        took.framing_error = in_framing_error;
        took.parity_error  = in_parity_error;
        took.noise_error   = in_noise_error;
        took.overrun_error = in_overrun_error;
        took.tx_ready      = in_tx_ready;
        sb.apply_item(took);
      end
      if (cfg_valid && cfg_ready) sb.echo_on = cfg_echo_enable;
    end
  end

  function automatic item_t mk_item(kind_t k, logic [7:0] b, logic last, logic rxv,
                                    logic [3:0] errs, logic txr);
    item_t it;
    it.kind          = k;
    it.byte_value    = b;
    it.burst_end     = last;
    it.rx_valid      = rxv;
    it.framing_error = errs[3];
    it.parity_error  = errs[2];
    it.noise_error   = errs[1];
    it.overrun_error = errs[0];
    it.tx_ready      = txr;
    return it;
  endfunction

  // Sender: optional idle burst, then hold the item until it transfers.
  // valid stays high between back-to-back items.
  task automatic drive_item(item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= it.kind;
    in_byte_value    <= it.byte_value;
    in_burst_end     <= it.burst_end;
    in_rx_valid      <= it.rx_valid;
    in_framing_error <= it.framing_error;
    in_parity_error  <= it.parity_error;
    in_noise_error   <= it.noise_error;
    in_overrun_error <= it.overrun_error;
    in_tx_ready      <= it.tx_ready;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Stop sending and wait for every outstanding result. The first edge lets
  // the monitor record an item accepted at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Only called when drained; cfg_ready is the block's own idle indication.
  task automatic write_echo(logic v);
    cfg_valid       <= 1'b1;
    cfg_echo_enable <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // One stretch of random traffic. Writes come in bursts of 1 to 8 bytes
  // with burst_end on the last one, plus an occasional stray burst_end
  // flip. The fill modes overrun a ring on purpose so that full-ring
  // refusal and receive drops get hit.
  task automatic run_segment(seg_mode_t mode, int n);
    item_t       it;
    int unsigned r, w_write, w_line, w_read, rxv_pct, txr_pct;
    case (mode)
      SEG_FILL_TX: begin w_write = 85; w_line = 93; w_read = 98; rxv_pct = 50; txr_pct = 10; end
      SEG_FILL_RX: begin w_write = 5;  w_line = 90; w_read = 98; rxv_pct = 95; txr_pct = 50; end
      SEG_DRAIN:   begin w_write = 5;  w_line = 50; w_read = 97; rxv_pct = 20; txr_pct = 95; end
      default:     begin w_write = 30; w_line = 60; w_read = 95; rxv_pct = 50; txr_pct = 50; end
    endcase
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      it = mk_item(KIND_PURGE, 8'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                   1'($urandom));
      if (r < w_write) begin
        it.kind = KIND_WRITE;
        if (burst_left == 0) burst_left = $urandom_range(1, 8);
        burst_left--;
        it.burst_end = (burst_left == 0);
        if ($urandom_range(0, 99) < 3) it.burst_end = !it.burst_end;
      end else if (r < w_line) begin
        it.kind          = KIND_LINE;
        it.rx_valid      = ($urandom_range(0, 99) < rxv_pct);
        it.tx_ready      = ($urandom_range(0, 99) < txr_pct);
        it.framing_error = ($urandom_range(0, 3) == 0);
        it.parity_error  = ($urandom_range(0, 3) == 0);
        it.noise_error   = ($urandom_range(0, 3) == 0);
        it.overrun_error = ($urandom_range(0, 3) == 0);
      end else if (r < w_read) begin
        it.kind = KIND_READ;
      end
      drive_item(it);
    end
  endtask

  initial begin
    int seg, done, n, total;
    seg_mode_t mode;
    total = 1950;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_echo(1'b0);

    // Directed: empty-ring corners, extreme bytes, all error flags, and
    // fields that only a line event uses set on the other kinds.
    drive_item(mk_item(KIND_READ,  8'h00, 1'b0, 1'b0, 4'h0, 1'b0)); // read while empty
    drive_item(mk_item(KIND_PURGE, 8'hFF, 1'b1, 1'b1, 4'hF, 1'b1)); // purge of empty ring
    drive_item(mk_item(KIND_LINE,  8'h00, 1'b0, 1'b0, 4'h0, 1'b1)); // ready, nothing queued
    drive_item(mk_item(KIND_WRITE, 8'h00, 1'b0, 1'b1, 4'hF, 1'b1)); // stray line fields ignored
    drive_item(mk_item(KIND_WRITE, 8'hFF, 1'b1, 1'b0, 4'h0, 1'b0));
    drive_item(mk_item(KIND_LINE,  8'hFF, 1'b0, 1'b1, 4'hF, 1'b1)); // every error at once
    drive_item(mk_item(KIND_LINE,  8'h00, 1'b1, 1'b1, 4'h5, 1'b1));
    drive_item(mk_item(KIND_LINE,  8'h3C, 1'b0, 1'b0, 4'hA, 1'b0)); // errors only
    drive_item(mk_item(KIND_READ,  8'h00, 1'b1, 1'b1, 4'hF, 1'b1));
    drive_item(mk_item(KIND_READ,  8'hFF, 1'b0, 1'b0, 4'h0, 1'b0));
    drive_item(mk_item(KIND_READ,  8'h00, 1'b0, 1'b0, 4'h0, 1'b0)); // empty again
    drive_item(mk_item(KIND_LINE,  8'hA5, 1'b0, 1'b1, 4'h0, 1'b0));
    drive_item(mk_item(KIND_LINE,  8'h5A, 1'b0, 1'b1, 4'h0, 1'b1)); // ready, tx ring empty
    drive_item(mk_item(KIND_PURGE, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0)); // purge with data
    drive_item(mk_item(KIND_READ,  8'h00, 1'b0, 1'b0, 4'h0, 1'b0));
    drain();
    write_echo(1'b1);
    drive_item(mk_item(KIND_LINE,  8'h81, 1'b0, 1'b1, 4'h0, 1'b0)); // echoed
    drive_item(mk_item(KIND_LINE,  8'h7E, 1'b0, 1'b0, 4'h3, 1'b0)); // no byte, no echo
    drive_item(mk_item(KIND_READ,  8'h00, 1'b0, 1'b0, 4'h0, 1'b0));
    drain();

    // Random: rotate through traffic shapes. Each mix segment starts from a
    // drained block and rewrites echo_enable, so the first receive-fill runs
    // with echo on (drops still echoed) and the next with echo off.
    seg = 0;
    done = 0;
    while (done < total) begin
      mode = seg_mode_t'(seg % 4);
      if (mode == SEG_MIX) begin
        drain();
        write_echo(((seg / 4) % 2) == 0);
      end
      n = (mode == SEG_FILL_TX || mode == SEG_FILL_RX) ? 400 : $urandom_range(80, 200);
      if (n > total - done) n = total - done;
      // the tail of the run goes back to back on both sides
      if (total - done <= 200)  idle_pct = 0;
      else if (seg % 3 == 1)    idle_pct = 0;
      else                      idle_pct = 25;
      run_segment(mode, n);
      done += n;
      seg++;
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Ran %0d items over %0d segments; echo on and off, both rings filled past full.",
             sb.items, seg);
    $display("Refused writes %0d, dropped rx bytes %0d, echoes %0d, sends %0d, reads %0d.",
             sb.n_refused, sb.n_dropped, sb.n_echoed, sb.n_sent, sb.n_read);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[uart_ring_buffer_engine_core] OK");
    end else begin
      $display("[uart_ring_buffer_engine_core] ERROR");
    end
    $finish;
  end

endmodule
